@@ design/multi_charset_char_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// multi_charset_char_decoder_defines
// assertion macros used by the decoder queue
// ----------------------------------------------------------------------------
`ifndef MULTI_CHARSET_CHAR_DECODER_DEFINES_SVH
`define MULTI_CHARSET_CHAR_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define MCCD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mccd assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define MCCD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mccd assertion failed");

`endif

@@ design/mccd_pkg.sv @@
// ----------------------------------------------------------------------------
// mccd_pkg
// shared types, codes and helper functions of the charset decoder
// ----------------------------------------------------------------------------
package mccd_pkg;

	// field widths
	localparam int CODE_W = 31;
	localparam int CNT_W  = 3;
	localparam int ADDR_W = 3;

	// default depth of the queue between front and back
	localparam int QDEPTH = 4;

	// register index carried by paddr[2]
	localparam logic REG_CHARSET_MODE = 1'b0;

	// charset modes
	localparam logic [2:0] MODE_ASCII = 3'd0;
	localparam logic [2:0] MODE_GBK   = 3'd1;
	localparam logic [2:0] MODE_UCS2  = 3'd2;
	localparam logic [2:0] MODE_UTF8  = 3'd3;
	localparam logic [2:0] MODE_RAW   = 3'd4;

	// one queue entry: one or two results caused by a single byte
	typedef struct packed {
		logic [CODE_W-1:0] code0;
		logic [CNT_W-1:0]  cnt0;
		logic              two;
		logic [CODE_W-1:0] code1;
		logic [CNT_W-1:0]  cnt1;
	} evt_t;

	// utf-8 sequence length from the lead byte, zero for an invalid lead
	function automatic logic [2:0] utf8_len(input logic [7:0] b);
		logic [2:0] n;
		priority if (b[7] == 1'b0)         n = 3'd1;
		else if (b[7:6] == 2'b10)          n = 3'd0;
		else if (b[7:5] == 3'b110)         n = 3'd2;
		else if (b[7:4] == 4'b1110)        n = 3'd3;
		else if (b[7:3] == 5'b11110)       n = 3'd4;
		else if (b[7:2] == 6'b111110)      n = 3'd5;
		else if (b[7:1] == 7'b1111110)     n = 3'd6;
		else                               n = 3'd0;
		return n;
	endfunction

	// payload bits kept from a multi-byte lead: 0x7F >> n
	function automatic logic [7:0] lead_mask(input logic [2:0] n);
		logic [7:0] m;
		unique case (n)
			3'd2:    m = 8'h1F;
			3'd3:    m = 8'h0F;
			3'd4:    m = 8'h07;
			3'd5:    m = 8'h03;
			3'd6:    m = 8'h01;
			default: m = 8'hFF;
		endcase
		return m;
	endfunction

endpackage

@@ design/multi_charset_char_decoder.sv @@
// Path: an accepted byte goes into the queue and then into the held entry of
// the back that drives the ports; a byte only opening a character gives none.
// Throughput: one byte per cycle while the queue is not full; a byte with two
// results takes two pops, and the queue of QUEUE_DEPTH entries absorbs the gap.
// Reset: asynchronous, active low; mode goes to ascii fold, no character is
// open and the queue is empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_charset_char_decoder
// byte stream to character code decoder for ascii, gbk, ucs-2, utf-8 and raw
// ----------------------------------------------------------------------------
module multi_charset_char_decoder
	import mccd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QDEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// byte input
	input  logic [7:0]        in_byte,
	input  logic              end_of_buffer,
	input  logic              push,
	output logic              full,
	// results
	output logic [CODE_W-1:0] code_value,
	output logic [CNT_W-1:0]  byte_count,
	output logic              run_last,
	output logic              empty,
	input  logic              pop
);

	logic [2:0] mode_q;
	logic       cfg_wr;
	logic       mode_wr;
	logic       accept;
	logic       emit;
	evt_t       evt;
	evt_t       q_data;
	logic       q_empty;
	logic       q_rd;

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign mode_wr = cfg_wr && (paddr[2] == REG_CHARSET_MODE);
	assign prdata  = (paddr[2] == REG_CHARSET_MODE) ? {29'b0, mode_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ASCII;
		end else if (mode_wr) begin
			mode_q <= pwdata[2:0];
		end
	end

	// input transfer
	assign accept = push && !full;

	mccd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode_q),
		.clear         (mode_wr),
		.accept        (accept),
		.in_byte       (in_byte),
		.end_of_buffer (end_of_buffer),
		.emit          (emit),
		.evt           (evt)
	);

	mccd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept && emit),
		.wdata  (evt),
		.full   (full),
		.rd     (q_rd),
		.rdata  (q_data),
		.empty  (q_empty)
	);

	mccd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (q_data),
		.q_empty    (q_empty),
		.q_rd       (q_rd),
		.code_value (code_value),
		.byte_count (byte_count),
		.run_last   (run_last),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

@@ design/mccd_front.sv @@
// ----------------------------------------------------------------------------
// mccd_front
// accepts bytes, tracks the open character and classifies each byte into
// zero, one or two results for the queue
// ----------------------------------------------------------------------------
module mccd_front
	import mccd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [2:0]        mode,
	input  logic              clear,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              end_of_buffer,
	output logic              emit,
	output evt_t              evt
);

	logic [CODE_W-1:0] part_q, part_d;
	logic [2:0]        exp_q, exp_d;
	logic [2:0]        taken_q, taken_d;
	logic              pend_q, pend_d;

	logic [2:0]        lead_len;
	logic              lead_single;
	logic [CODE_W-1:0] lead_code;
	logic [CODE_W-1:0] byte_code;
	logic [CODE_W-1:0] cont_code;
	logic [2:0]        cont_taken;
	logic [2:0]        cont_exp;

	// utf-8 lead classification
	always_comb begin
		lead_len    = utf8_len(in_byte);
		lead_single = (lead_len < 3'd2) || end_of_buffer;
		byte_code   = {{(CODE_W-8){1'b0}}, in_byte};
		if (lead_len < 3'd2) begin
			lead_code = byte_code;
		end else begin
			lead_code = {{(CODE_W-8){1'b0}}, in_byte & lead_mask(lead_len)};
		end
		cont_code  = {part_q[CODE_W-7:0], 6'b0} | {{(CODE_W-6){1'b0}}, in_byte[5:0]};
		cont_taken = taken_q + 3'd1;
		cont_exp   = exp_q - 3'd1;
	end

	// decode of one byte per mode
	always_comb begin
		emit    = 1'b0;
		evt     = '0;
		part_d  = part_q;
		exp_d   = exp_q;
		taken_d = taken_q;
		pend_d  = pend_q;
		unique case (mode)
			MODE_ASCII: begin
				emit      = 1'b1;
				evt.cnt0  = 3'd1;
				if (in_byte >= 8'h41 && in_byte <= 8'h5A) begin
					evt.code0 = byte_code + CODE_W'(32);
				end else begin
					evt.code0 = byte_code;
				end
			end
			MODE_GBK, MODE_UCS2: begin
				if (pend_q) begin
					emit      = 1'b1;
					evt.code0 = {{(CODE_W-16){1'b0}}, part_q[7:0], in_byte};
					evt.cnt0  = 3'd2;
					part_d    = '0;
					exp_d     = '0;
					taken_d   = '0;
					pend_d    = 1'b0;
				end else if (end_of_buffer || (mode == MODE_GBK && !in_byte[7])) begin
					emit      = 1'b1;
					evt.code0 = byte_code;
					evt.cnt0  = 3'd1;
				end else begin
					part_d  = byte_code;
					exp_d   = 3'd1;
					taken_d = 3'd1;
					pend_d  = 1'b1;
				end
			end
			MODE_UTF8: begin
				if (!pend_q) begin
					if (lead_single) begin
						emit      = 1'b1;
						evt.code0 = lead_code;
						evt.cnt0  = 3'd1;
					end else begin
						part_d  = lead_code;
						exp_d   = lead_len - 3'd1;
						taken_d = 3'd1;
						pend_d  = 1'b1;
					end
				end else if (in_byte[7:6] == 2'b10) begin
					if (cont_exp == 3'd0 || end_of_buffer) begin
						emit      = 1'b1;
						evt.code0 = cont_code;
						evt.cnt0  = cont_taken;
						part_d    = '0;
						exp_d     = '0;
						taken_d   = '0;
						pend_d    = 1'b0;
					end else begin
						part_d  = cont_code;
						exp_d   = cont_exp;
						taken_d = cont_taken;
					end
				end else begin
					// bad continuation: flush, then treat the byte as a lead
					emit      = 1'b1;
					evt.code0 = part_q;
					evt.cnt0  = taken_q;
					if (lead_single) begin
						evt.two   = 1'b1;
						evt.code1 = lead_code;
						evt.cnt1  = 3'd1;
						part_d    = '0;
						exp_d     = '0;
						taken_d   = '0;
						pend_d    = 1'b0;
					end else begin
						part_d  = lead_code;
						exp_d   = lead_len - 3'd1;
						taken_d = 3'd1;
						pend_d  = 1'b1;
					end
				end
			end
			default: begin
				emit      = 1'b1;
				evt.code0 = byte_code;
				evt.cnt0  = 3'd1;
			end
		endcase
	end

	// open character state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q  <= '0;
			exp_q   <= '0;
			taken_q <= '0;
			pend_q  <= 1'b0;
		end else if (clear) begin
			part_q  <= '0;
			exp_q   <= '0;
			taken_q <= '0;
			pend_q  <= 1'b0;
		end else if (accept) begin
			part_q  <= part_d;
			exp_q   <= exp_d;
			taken_q <= taken_d;
			pend_q  <= pend_d;
		end
	end

endmodule

@@ design/mccd_fifo.sv @@
// ----------------------------------------------------------------------------
// mccd_fifo
// short queue of result entries between the front and the back
// ----------------------------------------------------------------------------
`include "multi_charset_char_decoder_defines.svh"

module mccd_fifo
	import mccd_pkg::*;
#(
	parameter int DEPTH = QDEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  evt_t wdata,
	output logic full,
	input  logic rd,
	output evt_t rdata,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	evt_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// queue checks
	`MCCD_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
	`MCCD_ASSERT_NXT(a_wr_fills, do_wr && !do_rd, count_q == $past(count_q) + 1'b1)
	`MCCD_ASSERT_NXT(a_rd_drains, do_rd && !do_wr, count_q == $past(count_q) - 1'b1)
	`MCCD_ASSERT_NXT(a_wr_not_empty, do_wr, !empty)

endmodule

@@ design/mccd_back.sv @@
// ----------------------------------------------------------------------------
// mccd_back
// takes queue entries and hands out their results one transfer at a time
// ----------------------------------------------------------------------------
module mccd_back
	import mccd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  evt_t              q_data,
	input  logic              q_empty,
	output logic              q_rd,
	output logic [CODE_W-1:0] code_value,
	output logic [CNT_W-1:0]  byte_count,
	output logic              run_last,
	output logic              empty,
	input  logic              pop
);

	evt_t cur_q;
	logic valid_q;
	logic phase_q;
	logic last_now;
	logic pop_ok;
	logic pop_last;

	assign last_now = phase_q || !cur_q.two;
	assign pop_ok   = pop && valid_q;
	assign pop_last = pop_ok && last_now;
	assign q_rd     = !q_empty && (!valid_q || pop_last);

	// result ports from the held entry
	assign empty      = !valid_q;
	assign code_value = phase_q ? cur_q.code1 : cur_q.code0;
	assign byte_count = phase_q ? cur_q.cnt1 : cur_q.cnt0;
	assign run_last   = last_now;

	// held entry payload
	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_data;
		end
	end

	// entry valid and result phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (pop_last) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (pop_ok) begin
			phase_q <= 1'b1;
		end
	end

endmodule
